### sv/bcu_pkg.sv
// shared types and constants for the binomial coefficient unit
package bcu_pkg;

    localparam int NW     = 8;                // width of n and r
    localparam int ValueW = 31;               // width of the result value
    localparam int ProdW  = ValueW + NW;      // running value times falling factor
    localparam int CntW   = $clog2(ProdW + 1);

    // largest n accepted
    localparam logic [9:0] MaxN = 10'd255;

    localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

    typedef struct packed {
        logic             start;
        logic [ProdW-1:0] dividend;
        logic [NW-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ProdW-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

### sv/bcu_div.sv
// restoring divider, one quotient bit per cycle
module bcu_div
    import bcu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [ProdW-1:0] quo_reg;
    logic [ProdW-1:0] quo_next;
    logic [NW-1:0]    rem_reg;
    logic [NW-1:0]    rem_next;
    logic [NW-1:0]    dvs_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NW:0]      shifted;
    logic [NW:0]      diff;
    logic             fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[ProdW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = (shifted >= {1'b0, dvs_reg});
        rem_next = fits ? diff[NW-1:0] : shifted[NW-1:0];
        quo_next = {quo_reg[ProdW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(ProdW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/binomial_coefficient_unit.sv
// top level: sequencer for n choose r over one shared multiply and divide step
// each step: multiply, divide, quotient take; then the output register is loaded;
//   at most 16 steps run before the value is final or saturated
// throughput: one item at a time, a new (n, r) pair is taken only once the last result is loaded
// reset: rst_n asynchronous active low clears the sequencer and output valid
module binomial_coefficient_unit
    import bcu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // n [7:0], r [15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value [30:0], zero [31]
    output logic [1:0]  m_tuser    // overflow [0], invalid [1]
);

    state_t              state_reg;
    state_t              state_next;
    logic [NW-1:0]       n_reg;
    logic [NW-1:0]       k_reg;
    logic [NW-1:0]       i_reg;
    logic [ValueW-1:0]   acc_reg;
    logic                ovf_reg;
    logic                inv_reg;
    logic                m_tvalid_reg;
    logic [ValueW-1:0]   value_reg;
    logic                ovf_out_reg;
    logic                inv_out_reg;

    logic [NW-1:0]       n_in;
    logic [NW-1:0]       r_in;
    logic [NW-1:0]       nmr;
    logic [NW-1:0]       k_in;
    logic                inv_in;
    logic [NW-1:0]       factor;
    logic                out_free;
    logic                big;
    div_req_t            dreq;
    div_rsp_t            drsp;

    assign n_in     = s_tdata[7:0];
    assign r_in     = s_tdata[15:8];
    assign nmr      = n_in - r_in;
    assign k_in     = (r_in < nmr) ? r_in : nmr;
    assign inv_in   = (r_in > n_in) || ({2'b00, n_in} > MaxN);
    assign factor   = n_reg - i_reg + 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign big      = |drsp.quotient[ProdW-1:ValueW];

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        dreq.start    = (state_reg == ST_MUL);
        dreq.dividend = ProdW'(acc_reg) * ProdW'(factor);
        dreq.divisor  = i_reg;
    end

    bcu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (inv_in || k_in == '0) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    state_next = (big || i_reg == k_reg) ? ST_FIN : ST_MUL;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                n_reg   <= n_in;
                k_reg   <= k_in;
                i_reg   <= {{(NW-1){1'b0}}, 1'b1};
                acc_reg <= {{(ValueW-1){1'b0}}, 1'b1};
                ovf_reg <= 1'b0;
                inv_reg <= inv_in;
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    acc_reg <= drsp.quotient[ValueW-1:0];
                    ovf_reg <= big;
                    i_reg   <= i_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    // invalid wins, then saturation
                    value_reg   <= inv_reg ? '0 : (ovf_reg ? ValueMax : acc_reg);
                    ovf_out_reg <= ovf_reg && !inv_reg;
                    inv_out_reg <= inv_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, value_reg};
    assign m_tuser  = {inv_out_reg, ovf_out_reg};

endmodule

### dv/tb_binomial_coefficient_unit.sv
// testbench for binomial_coefficient_unit: directed and random (n, r) pairs vs a predictor
`timescale 1ns / 100ps

module tb_binomial_coefficient_unit;
    import bcu_pkg::*;

    localparam int NUM_ROWS     = 22;
    localparam int RAND_ITEMS   = 108;
    localparam int QUIET_ITEMS  = 20;
    localparam int DRAIN_CYCLES = 5300;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              overflow;
        logic              invalid;
    } coef_t;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [NW-1:0] r;
        logic          typed;
        coef_t         want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // n [7:0], r [15:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // value [30:0], zero [31]
    logic [1:0]  m_tuser;   // overflow [0], invalid [1]

    coef_t pending_coef [$];
    coef_t want_coef;
    int    mismatch_count;
    int    cycle_count;
    bit    quiet_phase;
    row_t  dir_rows [NUM_ROWS];

    binomial_coefficient_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // multiplicative recurrence, stopping as soon as the running value saturates
    function automatic coef_t choose(input logic [NW-1:0] n, input logic [NW-1:0] r);
        coef_t       res;
        logic [63:0] acc;
        int unsigned steps;
        res   = '0;
        acc   = 64'd1;
        if (r > n || {2'b00, n} > MaxN)
        begin
            res.invalid = 1'b1;
            return res;
        end
        steps = 32'((r < n - r) ? r : n - r);
        for (int unsigned i = 1; i <= steps; i++)
        begin
            acc = acc * 64'(n - i + 1);
            acc = acc / 64'(i);
            if (acc > 64'(ValueMax))
            begin
                res.overflow = 1'b1;
                break;
            end
        end
        res.value = res.overflow ? ValueMax : acc[ValueW-1:0];
        return res;
    endfunction

    task automatic send_pair(input logic [NW-1:0] n, input logic [NW-1:0] r,
                             input logic typed, input coef_t want, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, n};
        do @(posedge clk); while (!s_tready);
        pending_coef.push_back(typed ? want : choose(n, r));
        @(negedge clk);
    endtask

    function automatic int pick_gap();
        if (quiet_phase || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_coef.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transfer: tdata=%h tuser=%b",
                             m_tdata, m_tuser);
            end
            else
            begin
                want_coef = pending_coef.pop_front();
                if (m_tdata[ValueW-1:0] !== want_coef.value || m_tdata[31] !== 1'b0
                    || m_tuser[0] !== want_coef.overflow || m_tuser[1] !== want_coef.invalid)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected value=%0d ovf=%b inv=%b, %s%h ovf=%b inv=%b",
                                 want_coef.value, want_coef.overflow, want_coef.invalid,
                                 "got tdata=", m_tdata, m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side backpressure
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet_phase)
                m_tready <= 1'b1;
            else if ($urandom_range(0, 1) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40) - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [NW-1:0] n;
        logic [NW-1:0] r;
        int            sel;
        int            span;

        mismatch_count = 0;
        cycle_count    = 0;
        quiet_phase    = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        rst_n          = 1'b0;

        dir_rows = '{
            '{8'd0,   8'd0,   1'b1, '{31'd1, 1'b0, 1'b0}},
            '{8'd255, 8'd0,   1'b1, '{31'd1, 1'b0, 1'b0}},
            '{8'd255, 8'd255, 1'b1, '{31'd1, 1'b0, 1'b0}},
            '{8'd1,   8'd1,   1'b1, '{31'd1, 1'b0, 1'b0}},
            '{8'd0,   8'd255, 1'b1, '{31'd0, 1'b0, 1'b1}},
            '{8'd3,   8'd4,   1'b1, '{31'd0, 1'b0, 1'b1}},
            '{8'd254, 8'd255, 1'b1, '{31'd0, 1'b0, 1'b1}},
            '{8'd85,  8'd170, 1'b1, '{31'd0, 1'b0, 1'b1}},
            '{8'd255, 8'd1,   1'b1, '{31'd255, 1'b0, 1'b0}},
            '{8'd255, 8'd254, 1'b1, '{31'd255, 1'b0, 1'b0}},
            '{8'd255, 8'd128, 1'b1, '{ValueMax, 1'b1, 1'b0}},
            '{8'd255, 8'd127, 1'b1, '{ValueMax, 1'b1, 1'b0}},
            '{8'd170, 8'd85,  1'b1, '{ValueMax, 1'b1, 1'b0}},
            '{8'd128, 8'd64,  1'b0, '0},
            '{8'd34,  8'd17,  1'b0, '0},
            '{8'd35,  8'd17,  1'b0, '0},
            '{8'd33,  8'd16,  1'b0, '0},
            '{8'd31,  8'd15,  1'b0, '0},
            '{8'd10,  8'd5,   1'b0, '0},
            '{8'd2,   8'd1,   1'b0, '0},
            '{8'd67,  8'd9,   1'b0, '0},
            '{8'd253, 8'd4,   1'b0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_pair(dir_rows[i].n, dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want,
                      pick_gap());

        for (int idx = 0; idx < RAND_ITEMS; idx++)
        begin
            if (idx == RAND_ITEMS - QUIET_ITEMS)
                quiet_phase = 1'b1;
            // hold off until everything in flight has come back
            if (idx == RAND_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
                wait (pending_coef.size() == 0);
                @(negedge clk);
            end
            sel = $urandom_range(0, 9);
            if (sel <= 3)
            begin
                n = NW'($urandom_range(0, 40));
                r = NW'($urandom_range(0, n));
            end
            else if (sel <= 5)
            begin
                n = NW'($urandom_range(0, 255));
                r = NW'($urandom_range(0, n));
            end
            else if (sel == 6)
            begin
                // near the edges: r or n - r no more than 6, where large n can still saturate
                n    = NW'($urandom_range(0, 255));
                span = (n < 6) ? int'(n) : 6;
                r    = NW'($urandom_range(0, span));
                if ($urandom_range(0, 1) == 1)
                    r = n - r;
            end
            else if (sel == 7)
            begin
                n = NW'($urandom_range(0, 254));
                r = NW'($urandom_range(n + 1, 255));
            end
            else
            begin
                n = NW'($urandom_range(0, 255));
                r = NW'($urandom_range(0, 255));
            end
            send_pair(n, r, 1'b0, '0, pick_gap());
        end
        s_tvalid <= 1'b0;

        wait (pending_coef.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_coef.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
sv/bcu_pkg.sv
sv/bcu_div.sv
sv/binomial_coefficient_unit.sv
dv/tb_binomial_coefficient_unit.sv
